### rtl/core/thc_pkg.sv
// Shared types, constants and arithmetic helpers for the compensation pipeline.
package thc_pkg;

  localparam int unsigned CFG_DATA_W = 24;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned RAW_T_W    = 20;
  localparam int unsigned RAW_H_W    = 16;
  localparam int unsigned TEMP_W     = 15;
  localparam int unsigned HUM_W      = 14;
  localparam int unsigned HQ_W       = 17;

  localparam int unsigned FINE_LAT  = 4;
  localparam int unsigned TEMP_LAT  = 6;
  localparam int unsigned HUM_LAT   = 12;
  localparam int unsigned TOTAL_LAT = FINE_LAT + HUM_LAT;

  localparam logic signed [31:0] TEMP_MIN     = -32'sd4000;
  localparam logic signed [31:0] TEMP_MAX     = 32'sd8500;
  localparam logic signed [31:0] HUM_T_OFFSET = 32'sd76800;
  localparam logic signed [31:0] HUM_ACC_MAX  = 32'sd419430400;
  localparam logic [HQ_W-1:0]    HUM_Q_MAX    = HQ_W'(100000);
  localparam logic [HUM_W-1:0]   HUM_OUT_MAX  = HUM_W'(9765);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_T1    = 3'd0,
    REG_T2    = 3'd1,
    REG_T3    = 3'd2,
    REG_H1    = 3'd3,
    REG_H2    = 3'd4,
    REG_H3    = 3'd5,
    REG_H4_H5 = 3'd6,
    REG_H6    = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [15:0]        t1;
    logic signed [15:0] t2;
    logic signed [15:0] t3;
    logic [7:0]         h1;
    logic signed [15:0] h2;
    logic [7:0]         h3;
    logic signed [11:0] h4;
    logic signed [11:0] h5;
    logic signed [7:0]  h6;
  } coeff_t;

  // Low 32 bits of a signed product, as two's complement.
  function automatic logic signed [31:0] mul32(input logic signed [31:0] x,
                                               input logic signed [31:0] y);
    logic signed [63:0] p;
    p = x * y;
    return signed'(p[31:0]);
  endfunction

  // Signed division by 2**sh, truncating toward zero.
  function automatic logic signed [31:0] div_p2(input logic signed [31:0] x,
                                                input logic [4:0] sh);
    logic signed [31:0] bias;
    bias = x[31] ? ((32'sd1 <<< sh) - 32'sd1) : 32'sd0;
    return (x + bias) >>> sh;
  endfunction

endpackage

### rtl/core/thc_cfg_regs.sv
// Calibration coefficient registers with a plain write port.
module thc_cfg_regs import thc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output coeff_t                coeff
);

  always_ff @(posedge clk) begin
    if (rst) begin
      coeff <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx_t'(cfg_index))
        REG_T1:    coeff.t1 <= cfg_data[15:0];
        REG_T2:    coeff.t2 <= signed'(cfg_data[15:0]);
        REG_T3:    coeff.t3 <= signed'(cfg_data[15:0]);
        REG_H1:    coeff.h1 <= cfg_data[7:0];
        REG_H2:    coeff.h2 <= signed'(cfg_data[15:0]);
        REG_H3:    coeff.h3 <= cfg_data[7:0];
        REG_H4_H5: begin
          coeff.h4 <= signed'(cfg_data[23:12]);
          coeff.h5 <= signed'(cfg_data[11:0]);
        end
        REG_H6:    coeff.h6 <= signed'(cfg_data[7:0]);
        default: ;
      endcase
    end
  end

endmodule

### rtl/core/thc_temp_pipe.sv
// Temperature pipeline: fine temperature and clamped temperature in hundredths.
module thc_temp_pipe import thc_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  input  logic [RAW_T_W-1:0]       raw_temperature,
  input  coeff_t                   coeff,
  output logic                     fine_valid,
  output logic signed [31:0]       fine,
  output logic signed [TEMP_W-1:0] temperature_centi
);

  logic [FINE_LAT-2:0] vld;
  logic signed [31:0]  a1, b1, pa, pb, ta, pb2, pt;
  logic signed [31:0]  t1_ext, t2_ext, t3_ext, tsum, tclamp;

  assign t1_ext = signed'({16'd0, coeff.t1});
  assign t2_ext = signed'({{16{coeff.t2[15]}}, coeff.t2});
  assign t3_ext = signed'({{16{coeff.t3[15]}}, coeff.t3});

  always_ff @(posedge clk) begin
    if (rst) begin
      vld        <= '0;
      fine_valid <= 1'b0;
    end else begin
      vld        <= {vld[FINE_LAT-3:0], in_valid};
      fine_valid <= vld[FINE_LAT-2];
    end
  end

  always_ff @(posedge clk) begin
    a1   <= signed'({15'd0, raw_temperature[19:3]}) - (t1_ext <<< 1);
    b1   <= signed'({16'd0, raw_temperature[19:4]}) - t1_ext;
    pa   <= mul32(a1, t2_ext);
    pb   <= mul32(b1, b1);
    ta   <= div_p2(pa, 5'd11);
    pb2  <= mul32(div_p2(pb, 5'd12), t3_ext);
    fine <= ta + div_p2(pb2, 5'd14);
    pt   <= mul32(fine, 32'sd5);
    temperature_centi <= tclamp[TEMP_W-1:0];
  end

  always_comb begin
    tsum = div_p2(pt + 32'sd128, 5'd8);
    if (tsum < TEMP_MIN) begin
      tclamp = TEMP_MIN;
    end else if (tsum > TEMP_MAX) begin
      tclamp = TEMP_MAX;
    end else begin
      tclamp = tsum;
    end
  end

endmodule

### rtl/core/thc_hum_pipe.sv
// Humidity pipeline: polynomial, saturation correction, clamps and scaling.
module thc_hum_pipe import thc_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  input  logic signed [31:0]      fine,
  input  logic [RAW_H_W-1:0]      raw_humidity,
  input  coeff_t                  coeff,
  output logic                    out_valid,
  output logic [HUM_W-1:0]        humidity_centi
);

  logic [HUM_LAT-2:0]   vld;
  logic [RAW_H_W-1:0]   rh1, rh2;
  logic signed [31:0]   ha, pd, p6, p3;
  logic signed [31:0]   e3, e4, e5, e6, e7;
  logic signed [31:0]   hb, hc, pbd, hd, ph2, hb2;
  logic signed [31:0]   c8, c9, c10, sq, pd1;
  logic signed [31:0]   h1_ext, h2_ext, h3_ext, h4_sh, h5_ext, h6_ext;
  logic signed [31:0]   rh_sh, esum, e_acc, e_clamp;
  logic [HQ_W-1:0]      hq, hq_raw;
  logic [23:0]          hprod;

  assign h1_ext = signed'({24'd0, coeff.h1});
  assign h2_ext = signed'({{16{coeff.h2[15]}}, coeff.h2});
  assign h3_ext = signed'({24'd0, coeff.h3});
  assign h4_sh  = signed'({coeff.h4, 20'd0});
  assign h5_ext = signed'({{20{coeff.h5[11]}}, coeff.h5});
  assign h6_ext = signed'({{24{coeff.h6[7]}}, coeff.h6});
  assign rh_sh  = signed'({2'd0, rh2, 14'd0});
  assign esum   = rh_sh - h4_sh - pd + 32'sd16384;
  assign hprod  = 24'(hq) * 24'd100;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      out_valid <= 1'b0;
    end else begin
      vld       <= {vld[HUM_LAT-3:0], in_valid};
      out_valid <= vld[HUM_LAT-2];
    end
  end

  always_ff @(posedge clk) begin
    ha  <= fine - HUM_T_OFFSET;
    rh1 <= raw_humidity;
    pd  <= mul32(h5_ext, ha);
    p6  <= mul32(ha, h6_ext);
    p3  <= mul32(ha, h3_ext);
    rh2 <= rh1;
    e3  <= div_p2(esum, 5'd15);
    hb  <= div_p2(p6, 5'd10);
    hc  <= div_p2(p3, 5'd11) + 32'sd32768;
    pbd <= mul32(hb, hc);
    e4  <= e3;
    hd  <= div_p2(pbd, 5'd10) + 32'sd2097152;
    e5  <= e4;
    ph2 <= mul32(hd, h2_ext);
    e6  <= e5;
    hb2 <= div_p2(ph2 + 32'sd8192, 5'd14);
    e7  <= e6;
    c8  <= mul32(e7, hb2);
    sq  <= mul32(div_p2(c8, 5'd15), div_p2(c8, 5'd15));
    c9  <= c8;
    pd1 <= mul32(div_p2(sq, 5'd7), h1_ext);
    c10 <= c9;
    hq  <= hq_raw;
    humidity_centi <= hprod[23:10];
  end

  always_comb begin
    e_acc = c10 - div_p2(pd1, 5'd4);
    if (e_acc[31]) begin
      e_clamp = 32'sd0;
    end else if (e_acc > HUM_ACC_MAX) begin
      e_clamp = HUM_ACC_MAX;
    end else begin
      e_clamp = e_acc;
    end
    hq_raw = e_clamp[HQ_W+11:12];
    if (hq_raw > HUM_Q_MAX) begin
      hq_raw = HUM_Q_MAX;
    end
  end

endmodule

### rtl/core/temp_humidity_compensation_unit.sv
// Top level of the temperature and humidity compensation unit.
//
// Each item is one raw temperature and one raw humidity reading; it is
// taken when start is high and busy is low, and one item can be taken in
// every cycle. The compensated pair is on temperature_centi and
// humidity_centi for exactly one cycle while done is high. The receiver
// has no way to hold results off, so it must capture them in that cycle.
// The depth of the pipeline comes from the chain of dependent 32-bit
// multiplications: four stages form the fine temperature and twelve more
// evaluate and scale the humidity polynomial. busy is high during reset and
// for the first cycle after it. Coefficients are written through cfg_wr,
// cfg_index and cfg_data and must only change while no item is in flight.
module temp_humidity_compensation_unit import thc_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic [RAW_T_W-1:0]       raw_temperature,
  input  logic [RAW_H_W-1:0]       raw_humidity,
  input  logic                     cfg_wr,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_DATA_W-1:0]    cfg_data,
  output logic                     done,
  output logic signed [TEMP_W-1:0] temperature_centi,
  output logic [HUM_W-1:0]         humidity_centi
);

  localparam int unsigned TEMP_DLY = TOTAL_LAT - TEMP_LAT;

  coeff_t                   coeff;
  logic                     accept;
  logic                     fine_valid;
  logic signed [31:0]       fine;
  logic signed [TEMP_W-1:0] temp_early;
  logic [RAW_H_W-1:0]       rh_dly [FINE_LAT];
  logic signed [TEMP_W-1:0] temp_dly [TEMP_DLY];

  assign accept            = start && !busy;
  assign temperature_centi = temp_dly[TEMP_DLY-1];

  always_ff @(posedge clk) begin
    busy <= rst;
  end

  always_ff @(posedge clk) begin
    rh_dly[0]   <= raw_humidity;
    temp_dly[0] <= temp_early;
    for (int i = 1; i < FINE_LAT; i++) begin
      rh_dly[i] <= rh_dly[i-1];
    end
    for (int i = 1; i < TEMP_DLY; i++) begin
      temp_dly[i] <= temp_dly[i-1];
    end
  end

  thc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr    (cfg_wr),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .coeff     (coeff)
  );

  thc_temp_pipe u_temp (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (accept),
    .raw_temperature   (raw_temperature),
    .coeff             (coeff),
    .fine_valid        (fine_valid),
    .fine              (fine),
    .temperature_centi (temp_early)
  );

  thc_hum_pipe u_hum (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (fine_valid),
    .fine           (fine),
    .raw_humidity   (rh_dly[FINE_LAT-1]),
    .coeff          (coeff),
    .out_valid      (done),
    .humidity_centi (humidity_centi)
  );

endmodule

### rtl/core/thc_checker.sv
// Port-level assertions for the compensation unit, bound to the top level.
module thc_checker import thc_pkg::*; (
  input logic                     clk,
  input logic                     rst,
  input logic                     start,
  input logic                     busy,
  input logic [RAW_T_W-1:0]       raw_temperature,
  input logic [RAW_H_W-1:0]       raw_humidity,
  input logic                     cfg_wr,
  input logic [CFG_IDX_W-1:0]     cfg_index,
  input logic [CFG_DATA_W-1:0]    cfg_data,
  input logic                     done,
  input logic signed [TEMP_W-1:0] temperature_centi,
  input logic [HUM_W-1:0]         humidity_centi
);

  // A result must trace back to an item taken exactly one latency earlier.
  a_done_has_item: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, TOTAL_LAT))
    else $error("result without a matching item");

  a_busy_after_reset: assert property (@(posedge clk) disable iff (rst)
    busy == $past(rst))
    else $error("busy does not follow reset");

  a_temp_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (temperature_centi >= TEMP_W'(TEMP_MIN)) &&
             (temperature_centi <= TEMP_W'(TEMP_MAX)))
    else $error("temperature out of range");

  a_hum_range: assert property (@(posedge clk) disable iff (rst)
    done |-> humidity_centi <= HUM_OUT_MAX)
    else $error("humidity out of range");

endmodule

bind temp_humidity_compensation_unit thc_checker u_thc_checker (.*);

### tb/tb.sv
// Self-checking testbench for the temperature and humidity compensation unit.
`timescale 1ns / 1ps

module tb;
  import thc_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int REPORT_MAX  = 10;
  localparam int T_FLOOR     = -4000;
  localparam int T_CEIL      = 8500;
  localparam int FINE_OFFSET = 76800;
  localparam int ACC_CEIL    = 419430400;
  localparam int unsigned QUOT_CEIL = 100000;

  typedef enum {CAL_TYPICAL, CAL_JITTER, CAL_HIGH, CAL_LOW, CAL_RANDOM} cal_kind_t;

  typedef struct {
    logic [RAW_T_W-1:0] raw_t;
    logic [RAW_H_W-1:0] raw_h;
  } reading_t;

  typedef struct {
    logic signed [TEMP_W-1:0] temp;
    logic [HUM_W-1:0]         hum;
  } compensated_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     start = 1'b0;
  logic                     busy;
  logic [RAW_T_W-1:0]       raw_temperature = '0;
  logic [RAW_H_W-1:0]       raw_humidity = '0;
  logic                     cfg_wr = 1'b0;
  logic [CFG_IDX_W-1:0]     cfg_index = '0;
  logic [CFG_DATA_W-1:0]    cfg_data = '0;
  logic                     done;
  logic signed [TEMP_W-1:0] temperature_centi;
  logic [HUM_W-1:0]         humidity_centi;

  coeff_t       cal = '0;
  reading_t     reading_q[$];
  compensated_t compensated_q[$];
  int           sender_idle_pct = 0;
  int           error_count = 0;
  int           stall_cycles = 0;

  temp_humidity_compensation_unit dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .raw_temperature(raw_temperature),
    .raw_humidity(raw_humidity),
    .cfg_wr(cfg_wr),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .done(done),
    .temperature_centi(temperature_centi),
    .humidity_centi(humidity_centi)
  );

  always #5 clk = ~clk;

  // 32-bit int arithmetic (hum unsigned): products wrap, division truncates toward zero.
  function automatic compensated_t compensate(reading_t r);
    compensated_t res;
    int rt, rh, t1, t2, t3, h1, h2, h3, h4, h5, h6;
    int a, b, c, d, e, fine, temp;
    int unsigned hum;
    rt = int'({12'd0, r.raw_t});
    rh = int'({16'd0, r.raw_h});
    t1 = int'({16'd0, cal.t1});
    t2 = int'(cal.t2);
    t3 = int'(cal.t3);
    h1 = int'({24'd0, cal.h1});
    h2 = int'(cal.h2);
    h3 = int'({24'd0, cal.h3});
    h4 = int'(cal.h4);
    h5 = int'(cal.h5);
    h6 = int'(cal.h6);

    a = (rt / 8 - t1 * 2) * t2 / 2048;
    b = rt / 16 - t1;
    b = b * b / 4096 * t3 / 16384;
    fine = a + b;
    temp = (fine * 5 + 128) / 256;
    if (temp < T_FLOOR) temp = T_FLOOR;
    else if (temp > T_CEIL) temp = T_CEIL;

    a = fine - FINE_OFFSET;
    e = (rh * 16384 - h4 * 1048576 - h5 * a + 16384) / 32768;
    b = a * h6 / 1024;
    c = a * h3 / 2048;
    d = b * (c + 32768) / 1024 + 2097152;
    b = (d * h2 + 8192) / 16384;
    c = e * b;
    d = (c / 32768) * (c / 32768) / 128;
    e = c - d * h1 / 16;
    if (e < 0) e = 0;
    if (e > ACC_CEIL) e = ACC_CEIL;
    hum = e / 4096;
    if (hum > QUOT_CEIL) hum = QUOT_CEIL;
    hum = hum * 100 / 1024;

    res.temp = temp[TEMP_W-1:0];
    res.hum  = hum[HUM_W-1:0];
    return res;
  endfunction

  task automatic flag_error(string msg);
    if (error_count < REPORT_MAX) $display("mismatch: %s", msg);
    error_count++;
  endtask

  function automatic void queue_reading(logic [RAW_T_W-1:0] t, logic [RAW_H_W-1:0] h);
    reading_t r;
    r.raw_t = t;
    r.raw_h = h;
    reading_q.push_back(r);
  endfunction

  // Most readings fall where the typical calibration gives unclamped results.
  function automatic void queue_random_reading();
    if ($urandom_range(9) < 7) begin
      queue_reading(RAW_T_W'($urandom_range(720000, 300000)),
                    RAW_H_W'($urandom_range(60000, 10000)));
    end else begin
      queue_reading(RAW_T_W'($urandom), RAW_H_W'($urandom));
    end
  endfunction

  function automatic coeff_t make_coeffs(cal_kind_t kind);
    coeff_t c;
    logic [127:0] bits;
    case (kind)
      CAL_TYPICAL: begin
        c.t1 = 16'(27504); c.t2 = 16'(26435); c.t3 = 16'(-1000);
        c.h1 = 8'(75); c.h2 = 16'(362); c.h3 = 8'(0);
        c.h4 = 12'(313); c.h5 = 12'(50); c.h6 = 8'(30);
      end
      CAL_JITTER: begin
        c.t1 = 16'($urandom_range(29000, 26000));
        c.t2 = 16'($urandom_range(28000, 24000));
        c.t3 = 16'(int'($urandom_range(2000, 0)) - 1000);
        c.h1 = 8'($urandom_range(255, 0));
        c.h2 = 16'($urandom_range(420, 300));
        c.h3 = 8'($urandom_range(255, 0));
        c.h4 = 12'($urandom_range(400, 250));
        c.h5 = 12'(int'($urandom_range(100, 0)) - 20);
        c.h6 = 8'(int'($urandom_range(60, 0)) - 30);
      end
      CAL_HIGH: begin
        c.t1 = 16'hFFFF; c.t2 = 16'(32767); c.t3 = 16'(32767);
        c.h1 = 8'hFF; c.h2 = 16'(32767); c.h3 = 8'hFF;
        c.h4 = 12'(2047); c.h5 = 12'(2047); c.h6 = 8'(127);
      end
      CAL_LOW: begin
        c.t1 = 16'(0); c.t2 = 16'(-32768); c.t3 = 16'(-32768);
        c.h1 = 8'(0); c.h2 = 16'(-32768); c.h3 = 8'(0);
        c.h4 = 12'(-2048); c.h5 = 12'(-2048); c.h6 = 8'(-128);
      end
      default: begin
        bits = {$urandom, $urandom, $urandom, $urandom};
        c = bits[$bits(coeff_t)-1:0];
      end
    endcase
    return c;
  endfunction

  // Bits above the register width are filled with noise when junk is set.
  function automatic logic [CFG_DATA_W-1:0] padded(bit junk, int w,
                                                   logic [CFG_DATA_W-1:0] v);
    logic [CFG_DATA_W-1:0] m;
    m = (CFG_DATA_W'(1) << w) - CFG_DATA_W'(1);
    return ((junk ? CFG_DATA_W'($urandom) : '0) & ~m) | (v & m);
  endfunction

  task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] d);
    @(posedge clk);
    cfg_wr    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    case (idx)
      REG_T1:    cal.t1 = d[15:0];
      REG_T2:    cal.t2 = d[15:0];
      REG_T3:    cal.t3 = d[15:0];
      REG_H1:    cal.h1 = d[7:0];
      REG_H2:    cal.h2 = d[15:0];
      REG_H3:    cal.h3 = d[7:0];
      REG_H4_H5: begin
        cal.h4 = d[23:12];
        cal.h5 = d[11:0];
      end
      REG_H6:    cal.h6 = d[7:0];
      default: ;
    endcase
  endtask

  task automatic load_coeffs(coeff_t c, bit junk);
    write_reg(REG_T1, padded(junk, 16, CFG_DATA_W'(c.t1)));
    write_reg(REG_T2, padded(junk, 16, CFG_DATA_W'(c.t2)));
    write_reg(REG_T3, padded(junk, 16, CFG_DATA_W'(c.t3)));
    write_reg(REG_H1, padded(junk, 8, CFG_DATA_W'(c.h1)));
    write_reg(REG_H2, padded(junk, 16, CFG_DATA_W'(c.h2)));
    write_reg(REG_H3, padded(junk, 8, CFG_DATA_W'(c.h3)));
    write_reg(REG_H4_H5, {c.h4, c.h5});
    write_reg(REG_H6, padded(junk, 8, CFG_DATA_W'(c.h6)));
    @(posedge clk);
    cfg_wr <= 1'b0;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (reading_q.size() != 0 || start || compensated_q.size() != 0);
  endtask

  // The sender empties its queue halfway, so it pauses until all results are back.
  task automatic run_phase(cal_kind_t kind, bit junk, int idle, int n);
    wait_drained();
    load_coeffs(make_coeffs(kind), junk);
    sender_idle_pct = idle;
    repeat (n / 2) queue_random_reading();
    wait_drained();
    repeat (n - n / 2) queue_random_reading();
  endtask

  always @(posedge clk) begin : driver
    reading_t sent;
    reading_t nxt;
    if (start && !busy) begin
      sent.raw_t = raw_temperature;
      sent.raw_h = raw_humidity;
      compensated_q.push_back(compensate(sent));
    end
    if (!start || !busy) begin
      if (reading_q.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
        nxt = reading_q.pop_front();
        start           <= 1'b1;
        raw_temperature <= nxt.raw_t;
        raw_humidity    <= nxt.raw_h;
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : monitor
    compensated_t want;
    if (!rst && done) begin
      if (compensated_q.size() == 0) begin
        flag_error($sformatf("result with no item outstanding: temp %0d hum %0d",
                             temperature_centi, humidity_centi));
      end else begin
        want = compensated_q.pop_front();
        if (temperature_centi !== want.temp || humidity_centi !== want.hum) begin
          flag_error($sformatf("temp expected %0d got %0d, hum expected %0d got %0d",
                               want.temp, temperature_centi, want.hum, humidity_centi));
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if ((start && !busy) || done) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("timeout: no activity for %0d cycles, %0d results outstanding",
               stall_cycles, compensated_q.size());
      $display("TB_ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    load_coeffs(make_coeffs(CAL_TYPICAL), 1'b0);
    queue_reading(20'h00000, 16'h0000);
    queue_reading(20'hFFFFF, 16'hFFFF);
    queue_reading(20'h00000, 16'hFFFF);
    queue_reading(20'hFFFFF, 16'h0000);
    queue_reading(20'hAAAAA, 16'h5555);
    queue_reading(20'h55555, 16'hAAAA);
    queue_reading(20'h80000, 16'h8000);
    queue_reading(20'h7FFFF, 16'h7FFF);
    queue_reading(20'd519888, 16'd30000);
    queue_reading(20'd519888, 16'h0000);
    queue_reading(20'd519888, 16'hFFFF);
    queue_reading(20'd313000, 16'd40000);
    queue_reading(20'd313200, 16'd40000);
    queue_reading(20'd709700, 16'd20000);
    queue_reading(20'd710000, 16'd20000);
    queue_reading(20'd313000, 16'hFFFF);
    queue_reading(20'd710000, 16'hFFFF);
    queue_reading(20'd440000, 16'd65000);

    run_phase(CAL_TYPICAL, 1'b1, 0, 140);
    run_phase(CAL_TYPICAL, 1'b0, 58, 150);
    run_phase(CAL_HIGH, 1'b1, 10, 120);
    run_phase(CAL_LOW, 1'b0, 0, 120);
    run_phase(CAL_JITTER, 1'b0, 58, 150);
    run_phase(CAL_RANDOM, 1'b1, 10, 150);
    run_phase(CAL_JITTER, 1'b1, 0, 150);
    run_phase(CAL_TYPICAL, 1'b0, 58, 150);

    wait_drained();
    repeat (TOTAL_LAT + 4) @(posedge clk);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### sim.f
rtl/core/thc_pkg.sv
rtl/core/thc_cfg_regs.sv
rtl/core/thc_temp_pipe.sv
rtl/core/thc_hum_pipe.sv
rtl/core/temp_humidity_compensation_unit.sv
rtl/core/thc_checker.sv
tb/tb.sv
